### rtl/pal_pkg.sv
// Package for the positional array list: operation and status codes,
// sequencer states and default sizing. It depends on nothing else.
package pal_pkg;

  // Default number of list entries.
  localparam int unsigned PalDepth = 16;

  // Field widths of the words on the two channels.
  localparam int unsigned OpW     = 3;
  localparam int unsigned PosW    = 4;
  localparam int unsigned ValW    = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned FoundW  = 4;
  localparam int unsigned CountW  = 5;

  // Operation codes; the two codes above OP_READ are ignored.
  typedef enum logic [OpW-1:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_SEARCH = 3'd4,
    OP_READ   = 3'd5
  } op_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_DEL_RD,
    S_DEL_WR,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_READ_RD,
    S_READ_WAIT,
    S_FINISH
  } state_e;

endpackage

### rtl/pal_if.sv
// Channel interfaces of the positional array list: the operation word in
// and the result word out. They depend on pal_pkg for the field widths.
interface pal_in_if;
  logic                          valid;
  logic                          ready;
  logic [pal_pkg::OpW-1:0]       op;
  logic [pal_pkg::PosW-1:0]      position;
  logic signed [pal_pkg::ValW-1:0] value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface pal_out_if;
  logic                            valid;
  logic                            ready;
  logic [pal_pkg::StatusW-1:0]     status;
  logic [pal_pkg::FoundW-1:0]      found_index;
  logic signed [pal_pkg::ValW-1:0] read_value;
  logic [pal_pkg::CountW-1:0]      element_count;

  modport source (output valid, output status, output found_index, output read_value,
                  output element_count, input ready);
  modport sink   (input valid, input status, input found_index, input read_value,
                  input element_count, output ready);
endinterface

### rtl/positional_array_list.sv
// Top level of the positional array list: a single-port-style element memory
// driven by an operation sequencer. It depends on pal_pkg and pal_if.
//
//   channel  direction  word
//   in_i     sink       op, position, value
//   out_o    source     status, found_index, read_value, element_count
//
// One operation word is taken at a time, while the sequencer is idle; a
// finished result waits in the output register and does not block the next word.
// Clear, append, the spare codes and refused operations go straight to the finishing
// state; read passes S_READ_RD and S_READ_WAIT, a search reads and compares
// one entry at a time, and insert and delete move entries one by one, because
// each moved entry is one memory read followed by one write.
// Reset empties the list at once; the element memory itself is not cleared.
// A result that is not taken holds the sequencer in its finishing state.
module positional_array_list #(
  parameter int unsigned DEPTH = pal_pkg::PalDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  pal_in_if.sink    in_i,
  pal_out_if.source out_o
);
  import pal_pkg::*;

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > PosW) ? CW : PosW;

  state_e                 state_q, state_d;
  logic [AW-1:0]          k_q, k_d;
  logic [AW-1:0]          pos_q, pos_d;
  logic signed [ValW-1:0] val_q, val_d;
  logic [CW-1:0]          count_q, count_d;
  status_e                res_status_q, res_status_d;
  logic [FoundW-1:0]      res_found_q, res_found_d;
  logic signed [ValW-1:0] res_read_q, res_read_d;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic signed [ValW-1:0] mem_wdata, rdata_q;
  logic signed [ValW-1:0] mem [DEPTH];

  logic                   out_valid_q;
  status_e                out_status_q;
  logic [FoundW-1:0]      out_found_q;
  logic signed [ValW-1:0] out_read_q;
  logic [CountW-1:0]      out_count_q;
  logic                   out_free, load_out;

  logic [CMPW-1:0] pos_ext, cnt_ext, k_ext;
  logic            full;

  assign pos_ext  = CMPW'(in_i.position);
  assign cnt_ext  = CMPW'(count_q);
  assign k_ext    = CMPW'(k_q);
  assign full     = (cnt_ext == CMPW'(DEPTH));
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready = (state_q == S_IDLE);

  // Element memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // Sequencer state and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Working payload registers need no reset.
  always_ff @(posedge clk_i) begin
    k_q          <= k_d;
    pos_q        <= pos_d;
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_read_q   <= res_read_d;
  end

  // Next state, memory accesses and result assembly.
  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    pos_d        = pos_q;
    val_d        = val_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_read_d   = res_read_q;
    mem_we       = 1'b0;
    mem_waddr    = k_q;
    mem_wdata    = rdata_q;
    mem_raddr    = k_q;
    load_out     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          pos_d        = AW'(in_i.position);
          val_d        = in_i.value;
          res_status_d = ST_OK;
          res_found_d  = '0;
          res_read_d   = '0;
          state_d      = S_FINISH;
          case (op_e'(in_i.op))
            OP_CLEAR: begin
              count_d = '0;
            end
            OP_APPEND: begin
              if (full) begin
                res_status_d = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(count_q);
                mem_wdata = in_i.value;
                count_d   = count_q + CW'(1);
              end
            end
            OP_INSERT: begin
              if (pos_ext >= cnt_ext) begin
                res_status_d = ST_BADPOS;
              end else if (full) begin
                res_status_d = ST_FULL;
              end else begin
                k_d     = AW'(count_q);
                state_d = S_INS_RD;
              end
            end
            OP_DELETE: begin
              if (pos_ext >= cnt_ext) begin
                res_status_d = ST_BADPOS;
              end else if (pos_ext + CMPW'(1) == cnt_ext) begin
                // Deleting the last entry moves nothing.
                count_d = count_q - CW'(1);
              end else begin
                k_d     = AW'(in_i.position) + AW'(1);
                state_d = S_DEL_RD;
              end
            end
            OP_SEARCH: begin
              if (count_q == '0) begin
                res_status_d = ST_NOTFOUND;
              end else begin
                k_d     = '0;
                state_d = S_SRCH_RD;
              end
            end
            OP_READ: begin
              if (pos_ext >= cnt_ext) begin
                res_status_d = ST_BADPOS;
              end else begin
                state_d = S_READ_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Insert: move entries up from the top down to the position.
      S_INS_RD: begin
        mem_raddr = k_q - AW'(1);
        state_d   = S_INS_WR;
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k_q;
        mem_wdata = rdata_q;
        k_d       = k_q - AW'(1);
        state_d   = (k_q - AW'(1) == pos_q) ? S_INS_PUT : S_INS_RD;
      end
      S_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = val_q;
        count_d   = count_q + CW'(1);
        state_d   = S_FINISH;
      end

      // Delete: move entries above the position down by one place.
      S_DEL_RD: begin
        mem_raddr = k_q;
        state_d   = S_DEL_WR;
      end
      S_DEL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k_q - AW'(1);
        mem_wdata = rdata_q;
        if (k_ext + CMPW'(1) == cnt_ext) begin
          count_d = count_q - CW'(1);
          state_d = S_FINISH;
        end else begin
          k_d     = k_q + AW'(1);
          state_d = S_DEL_RD;
        end
      end

      // Search: scan from position zero until a match or the end.
      S_SRCH_RD: begin
        mem_raddr = k_q;
        state_d   = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (rdata_q == val_q) begin
          res_found_d = FoundW'(k_q);
          state_d     = S_FINISH;
        end else if (k_ext + CMPW'(1) == cnt_ext) begin
          res_status_d = ST_NOTFOUND;
          state_d      = S_FINISH;
        end else begin
          k_d     = k_q + AW'(1);
          state_d = S_SRCH_RD;
        end
      end

      // Read: one memory access at the position.
      S_READ_RD: begin
        mem_raddr = pos_q;
        state_d   = S_READ_WAIT;
      end
      S_READ_WAIT: begin
        res_read_d = rdata_q;
        state_d    = S_FINISH;
      end

      // Hand the result to the output register once it has room.
      S_FINISH: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: holds a result word until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_read_q   <= res_read_q;
      out_count_q  <= CountW'(count_q);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.found_index   = out_found_q;
  assign out_o.read_value    = out_read_q;
  assign out_o.element_count = out_count_q;

endmodule

### tb/pal_checker.sv
// Checker for the positional array list: watches the operation and result
// channels, keeps its own copy of the list and compares every result word.
// Depends on pal_pkg and on the channel interfaces in pal_if.
module pal_checker
  import pal_pkg::*;
#(
  parameter int unsigned DEPTH = PalDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pal_in_if           op_word_i,
  pal_out_if          result_word_i,
  output int unsigned fault_count_o,
  output int unsigned awaited_o,
  output int unsigned list_len_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    status_e                 status;
    logic [FoundW-1:0]       found_index;
    logic signed [ValW-1:0]  read_value;
    logic [CountW-1:0]       element_count;
  } list_answer_t;

  // Shadow copy of the list contents and its length.
  logic signed [ValW-1:0] shadow_store [DEPTH];
  int unsigned            shadow_len;
  list_answer_t           awaited_answers [$];
  int unsigned            faults;

  // Applies one operation to the shadow list and returns the answer it gives.
  function automatic list_answer_t apply_list_op(input logic [OpW-1:0]      op,
                                                 input logic [PosW-1:0]     pos,
                                                 input logic signed [ValW-1:0] val);
    list_answer_t ans;
    int unsigned  k;
    bit           hit;
    ans.status      = ST_OK;
    ans.found_index = '0;
    ans.read_value  = '0;
    hit             = 1'b0;
    case (op)
      OP_CLEAR: begin
        shadow_len = 0;
      end
      OP_APPEND: begin
        if (shadow_len >= DEPTH) begin
          ans.status = ST_FULL;
        end else begin
          shadow_store[shadow_len] = val;
          shadow_len++;
        end
      end
      OP_INSERT: begin
        // The position is checked before the list is tested for room.
        if (pos >= shadow_len) begin
          ans.status = ST_BADPOS;
        end else if (shadow_len >= DEPTH) begin
          ans.status = ST_FULL;
        end else begin
          for (k = shadow_len; k > pos; k--) shadow_store[k] = shadow_store[k - 1];
          shadow_store[pos] = val;
          shadow_len++;
        end
      end
      OP_DELETE: begin
        if (pos >= shadow_len) begin
          ans.status = ST_BADPOS;
        end else begin
          for (k = pos + 1; k < shadow_len; k++) shadow_store[k - 1] = shadow_store[k];
          shadow_len--;
        end
      end
      OP_SEARCH: begin
        // Lowest matching position wins.
        ans.status = ST_NOTFOUND;
        for (k = 0; k < shadow_len; k++) begin
          if (!hit && shadow_store[k] == val) begin
            hit             = 1'b1;
            ans.status      = ST_OK;
            ans.found_index = FoundW'(k);
          end
        end
      end
      OP_READ: begin
        if (pos >= shadow_len) begin
          ans.status = ST_BADPOS;
        end else begin
          ans.read_value = shadow_store[pos];
        end
      end
      default: begin
        // The two spare codes leave the list alone.
      end
    endcase
    ans.element_count = CountW'(shadow_len);
    return ans;
  endfunction

  task automatic log_fault(input string msg);
    if (faults < MaxReports) $display("[%0t] %s", $realtime, msg);
    faults++;
  endtask

  // Compare each result word with the oldest prediction, then predict for any
  // operation word taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    list_answer_t got;
    list_answer_t want;
    if (!rst_ni) begin
      shadow_len = 0;
      faults     = 0;
      awaited_answers.delete();
      for (int i = 0; i < DEPTH; i++) shadow_store[i] = '0;
    end else begin
      if (result_word_i.valid && result_word_i.ready) begin
        got.status        = status_e'(result_word_i.status);
        got.found_index   = result_word_i.found_index;
        got.read_value    = result_word_i.read_value;
        got.element_count = result_word_i.element_count;
        if (awaited_answers.size() == 0) begin
          log_fault($sformatf("result word with nothing awaited: status=%0d found=%0d value=%0d count=%0d",
                              got.status, got.found_index, got.read_value, got.element_count));
        end else begin
          want = awaited_answers.pop_front();
          if (got.status !== want.status || got.found_index !== want.found_index ||
              got.read_value !== want.read_value || got.element_count !== want.element_count) begin
            log_fault($sformatf({"mismatch: expected status=%0d found=%0d value=%0d count=%0d, ",
                                 "got status=%0d found=%0d value=%0d count=%0d"},
                                want.status, want.found_index, want.read_value, want.element_count,
                                got.status, got.found_index, got.read_value, got.element_count));
          end
        end
      end
      if (op_word_i.valid && op_word_i.ready) begin
        awaited_answers.push_back(apply_list_op(op_word_i.op, op_word_i.position, op_word_i.value));
      end
    end
    fault_count_o = faults;
    awaited_o     = awaited_answers.size();
    list_len_o    = shadow_len;
  end

endmodule

### tb/testbench.sv
// Top of the positional array list testbench: clock, reset, stimulus and the
// verdict. Depends on pal_pkg, pal_if, the block itself and pal_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pal_pkg::*;

  localparam int unsigned RandomWords = 1800;
  localparam int unsigned CalmWords   = 200;
  localparam int unsigned BlockWords  = 120;

  logic        clk = 1'b0;
  logic        rst_n;
  bit          pacing_on;
  int unsigned fault_count;
  int unsigned awaited;
  int unsigned list_len;

  pal_in_if  op_ch ();
  pal_out_if res_ch ();

  positional_array_list #(.DEPTH(PalDepth)) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (op_ch),
    .out_o  (res_ch)
  );

  pal_checker #(.DEPTH(PalDepth)) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .op_word_i     (op_ch),
    .result_word_i (res_ch),
    .fault_count_o (fault_count),
    .awaited_o     (awaited),
    .list_len_o    (list_len)
  );

  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  // Hard limit in case the block stops answering.
  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Offers one operation word, with an optional idle burst first; returns at
  // the falling edge after the word has been taken.
  task automatic push_word(input logic [OpW-1:0] op, input logic [PosW-1:0] pos,
                           input logic signed [ValW-1:0] val);
    int unsigned gap;
    if (pacing_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      op_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    op_ch.valid    <= 1'b1;
    op_ch.op       <= op;
    op_ch.position <= pos;
    op_ch.value    <= val;
    do @(posedge clk); while (!op_ch.ready);
    @(negedge clk);
  endtask

  // Holds the sender back until every awaited result word has come.
  task automatic drain_results();
    op_ch.valid <= 1'b0;
    do @(negedge clk); while (awaited != 0);
  endtask

  // Small values in four draws of ten, so that searches hit and duplicates appear.
  function automatic logic signed [ValW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return ValW'($urandom_range(0, 7));
    if (r == 4) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7FFF_FFFF;
        2:       return -32'sd1;
        default: return 32'sd0;
      endcase
    end
    return $urandom;
  endfunction

  // Operation mix: the bias leans towards filling, draining or balance.
  function automatic logic [OpW-1:0] choose_op(input int unsigned bias);
    int unsigned r, t_app, t_ins, t_del, t_srch;
    r = $urandom_range(0, 99);
    case (bias)
      0:       begin t_app = 45; t_ins = 70; t_del = 78; t_srch = 90; end
      1:       begin t_app = 15; t_ins = 25; t_del = 65; t_srch = 83; end
      default: begin t_app = 25; t_ins = 45; t_del = 65; t_srch = 83; end
    endcase
    if (r < 2) return OP_CLEAR;
    if (r < 5) return OpW'($urandom_range(6, 7));
    if (r < t_app) return OP_APPEND;
    if (r < t_ins) return OP_INSERT;
    if (r < t_del) return OP_DELETE;
    if (r < t_srch) return OP_SEARCH;
    return OP_READ;
  endfunction

  // Result side: random stall bursts while pacing is on.
  initial begin : result_pacing
    int unsigned stall;
    res_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (pacing_on && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 14);
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
    end
  end

  initial begin : stimulus
    int unsigned              k, useful, bias;
    logic [OpW-1:0]           op;
    logic [PosW-1:0]          pos;
    logic signed [ValW-1:0]   val;
    op_ch.valid    = 1'b0;
    op_ch.op       = '0;
    op_ch.position = '0;
    op_ch.value    = '0;
    pacing_on      = 1'b1;
    rst_n          = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Empty list: positional operations are refused and a search misses.
    push_word(OP_READ,   4'd0, 32'sd0);
    push_word(OP_DELETE, 4'd0, 32'sd0);
    push_word(OP_INSERT, 4'd0, 32'sd5);
    push_word(OP_SEARCH, 4'd0, 32'sd0);

    // Fill to capacity with the extremes and some repeated values.
    for (k = 0; k < PalDepth; k++) begin
      case (k)
        0:       val = 32'sh8000_0000;
        1:       val = 32'sh7FFF_FFFF;
        2:       val = -32'sd1;
        default: val = ValW'(k % 3);
      endcase
      push_word(OP_APPEND, PosW'(k), val);
    end

    // Full list refuses growth; searches find the lowest duplicate.
    push_word(OP_APPEND, 4'd0,  32'sd9);
    push_word(OP_INSERT, 4'd15, 32'sd9);
    push_word(OP_SEARCH, 4'd0,  32'sd0);
    push_word(OP_SEARCH, 4'd0,  32'sh7FFF_FFFF);
    push_word(OP_READ,   4'd15, 32'sd0);
    push_word(OP_DELETE, 4'd0,  32'sd0);
    push_word(OP_INSERT, 4'd15, -32'sd1);
    push_word(OpW'(6),   4'd15, 32'sh7FFF_FFFF);
    push_word(OpW'(7),   4'd0,  32'sh8000_0000);
    push_word(OP_CLEAR,  4'd0,  32'sd0);
    push_word(OP_READ,   4'd0,  32'sd0);
    drain_results();

    // Random words in blocks with a changing bias and pacing, calm at the end.
    useful = 0;
    bias   = 2;
    while (useful < RandomWords) begin
      if (useful % BlockWords == 0) begin
        bias      = $urandom_range(0, 2);
        pacing_on = (useful < RandomWords - CalmWords) && ($urandom_range(0, 3) != 0);
      end
      if (useful == RandomWords / 2) drain_results();
      op = choose_op(bias);
      if (list_len > 0 && $urandom_range(0, 9) < 8) begin
        pos = PosW'($urandom_range(0, list_len - 1));
      end else begin
        pos = PosW'($urandom_range(0, 15));
      end
      val = pick_value();
      push_word(op, pos, val);
      if (op <= OP_READ) useful++;
    end

    // Let the last result words arrive, then give the verdict.
    drain_results();
    repeat (2 * PalDepth + 8) @(negedge clk);
    if (fault_count == 0 && awaited == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/pal_pkg.sv
rtl/pal_if.sv
rtl/positional_array_list.sv
tb/pal_checker.sv
tb/testbench.sv
